// ----- design/bds_pkg.sv -----
// ----------------------------------------------------------------------------
// Baud divisor search package
// Shared widths, constants and the command and status bundles that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bds_pkg;

    // Field widths of the configuration register and the input word
    localparam int CLK_W  = 25;
    localparam int BAUD_W = 21;
    localparam int IN_W   = 24;

    // Divider operand widths: widest numerator is (clock << 7) plus half
    // of (baud << 4), the widest denominator is baud << 11.
    localparam int NUM_W  = 33;
    localparam int DEN_W  = 32;
    localparam int CNT_W  = $clog2(NUM_W + 1);

    // Search constants
    localparam int SCALE_W           = 4;
    localparam int TRIAL_W           = 4;
    localparam int SHIFT_W           = 3;
    localparam logic [TRIAL_W-1:0] SCALE_BIAS  = 4'd7;
    localparam logic [TRIAL_W-1:0] TRIAL_LAST  = 4'd14;
    localparam logic [NUM_W-1:0]   DOUBLE_LIMIT = 33'd32;
    localparam logic [CLK_W-1:0]   CLK_HZ_RESET = 25'd32000000;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;       // take a new input word
        logic start_div;  // launch the shared divider
        logic sel_ratio;  // divider operands are clock / baud
        logic cap_ratio;  // pick the oversampling mode from the quotient
        logic check;      // judge the current trial
        logic publish;    // move the result into the output register
    } bds_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic in_zero;    // incoming baud rate is zero
        logic div_done;   // divider quotient is ready
        logic fit;        // current trial gives a usable divisor
        logic last;       // current trial is the final scale
        logic out_free;   // output register can take a word
    } bds_sts_t;

endpackage

`default_nettype wire

// ----- design/baud_divisor_search.sv -----
// Flow: a zero baud rate goes from the taken word straight to the result
// hand-off; otherwise one ratio division and 1 to 15 scale trials run in
// turn on the shared bit-serial divider.
// Throughput: one request at a time; the next word is taken once the result
// sits in the output register, which holds it until the consumer takes it.
// Reset (rst_n, asynchronous): clock register back to 32000000, block idle.
// ----------------------------------------------------------------------------
// Baud divisor search top level
// Picks oversampling mode, baud scale and divisor for a fractional baud
// generator from the configured clock and a requested baud rate.
// ----------------------------------------------------------------------------
`default_nettype none

module baud_divisor_search
    import bds_pkg::*;
#(
    parameter int DIVISOR_WIDTH = 12
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wr_en,
    input  wire logic [CLK_W-1:0] cfg_wr_data,   // cpu_clock_hz
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [IN_W-1:0]  s_tdata,       // [20:0] baud_rate
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    // status, double_speed, scale_exponent (4), divisor (DIVISOR_WIDTH)
    output logic [((6 + DIVISOR_WIDTH + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int OUT_W   = ((6 + DIVISOR_WIDTH + 7) / 8) * 8;
    localparam int DIV_LSB = 6;
    localparam int DIV_MSB = DIVISOR_WIDTH + 5;

    bds_cmd_t cmd;
    bds_sts_t sts;

    bds_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bds_datapath
    #(
        .DIVISOR_WIDTH (DIVISOR_WIDTH),
        .OUT_W         (OUT_W)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cmd         (cmd),
        .sts         (sts)
    );

    // A taken request closes the input until its result is handed on.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted again while a search is running");

    // The divider never finishes while the block is waiting for input.
    assert property (@(posedge clk) disable iff (!rst_n)
        sts.div_done |-> !s_tready)
        else $error("divider finished while idle");

    // A found setting never carries a zero divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[DIV_MSB:DIV_LSB] != '0))
        else $error("found setting with zero divisor");

    // An impossible rate reports all other fields as zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[0]) |-> (m_tdata[DIV_MSB:1] == '0))
        else $error("impossible result with nonzero fields");

endmodule

`default_nettype wire

// ----- design/bds_divider.sv -----
// ----------------------------------------------------------------------------
// Baud divisor search divider
// Restoring unsigned divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bds_divider
    import bds_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic      [NUM_W-1:0] quo
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg, den_next;

    logic [DEN_W:0]   rem_shift;
    logic [DEN_W:0]   rem_diff;

    // One restoring step: shift in the next numerator bit, try to subtract
    assign rem_shift = {rem_reg, quo_reg[NUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, den_reg};

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        den_next   = den_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = CNT_W'(NUM_W);
            rem_next   = '0;
            quo_next   = num;
            den_next   = den;
        end
        else if (busy_reg)
        begin
            if (rem_shift >= {1'b0, den_reg})
            begin
                rem_next = rem_diff[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            count_next = count_reg - CNT_W'(1);
            if (count_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    // Operand and partial result registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

// ----- design/bds_datapath.sv -----
// ----------------------------------------------------------------------------
// Baud divisor search datapath
// Holds the clock register, the request, the trial operands, the shared
// divider, the fit check and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bds_datapath
    import bds_pkg::*;
#(
    parameter int DIVISOR_WIDTH = 12,
    parameter int OUT_W         = 24
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [CLK_W-1:0]  cfg_wr_data,
    input  wire logic [IN_W-1:0]   s_tdata,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic      [OUT_W-1:0]  m_tdata,
    input  wire bds_cmd_t          cmd,
    output bds_sts_t               sts
);

    localparam logic [TRIAL_W-1:0] SCALE_ZERO = SCALE_BIAS;

    logic [CLK_W-1:0]         clk_hz_reg;
    logic [BAUD_W-1:0]        baud_reg;
    logic                     dbl_reg;
    logic [TRIAL_W-1:0]       trial_reg;
    logic                     found_reg;
    logic [DIVISOR_WIDTH-1:0] res_div_reg;
    logic                     m_valid_reg;
    logic [OUT_W-1:0]         m_data_reg;

    logic [CLK_W-1:0]   den_base;
    logic               neg_scale;
    logic [SHIFT_W-1:0] k;
    logic [NUM_W-1:0]   clk_ext;
    logic [DEN_W-1:0]   den_shift;
    logic [NUM_W-1:0]   trial_num;
    logic [DEN_W-1:0]   trial_den;
    logic [NUM_W-1:0]   trial_sub;
    logic [NUM_W-1:0]   div_num;
    logic [DEN_W-1:0]   div_den;
    logic [NUM_W-1:0]   quo;
    logic               div_done;
    logic [NUM_W-1:0]   q_minus;
    logic               out_status;
    logic               out_dbl;
    logic [SCALE_W-1:0] out_scale;
    logic [DIVISOR_WIDTH-1:0] out_div;
    logic               out_free;

    // Denominator base: baud times the oversampling factor
    assign den_base  = dbl_reg ? {1'b0, baud_reg, 3'b000} : {baud_reg, 4'b0000};
    assign neg_scale = trial_reg < SCALE_ZERO;
    assign k         = neg_scale ? SHIFT_W'(SCALE_ZERO - trial_reg)
                                 : SHIFT_W'(trial_reg - SCALE_ZERO);
    assign clk_ext   = NUM_W'(clk_hz_reg);
    assign den_shift = DEN_W'(den_base) << k;

    // Trial operands; negative scales shift the clock, others the denominator
    always_comb
    begin
        if (neg_scale)
        begin
            trial_num = (clk_ext << k) + NUM_W'(den_base[CLK_W-1:1]);
            trial_den = DEN_W'(den_base);
            trial_sub = NUM_W'(1) << k;
        end
        else
        begin
            trial_num = clk_ext + NUM_W'(den_shift[DEN_W-1:1]);
            trial_den = den_shift;
            trial_sub = NUM_W'(1);
        end
    end

    assign div_num = cmd.sel_ratio ? clk_ext : trial_num;
    assign div_den = cmd.sel_ratio ? DEN_W'(baud_reg) : trial_den;

    bds_divider u_divider
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.start_div),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (quo)
    );

    // Fit check: no borrow and the difference fits the divisor width
    assign q_minus = quo - trial_sub;

    assign out_free     = !m_valid_reg || m_tready;
    assign sts.in_zero  = (s_tdata[BAUD_W-1:0] == '0);
    assign sts.div_done = div_done;
    assign sts.fit      = (quo >= trial_sub) && ((q_minus >> DIVISOR_WIDTH) == '0);
    assign sts.last     = (trial_reg == TRIAL_LAST);
    assign sts.out_free = out_free;

    // Result fields; an unusable or zero divisor reports impossible
    assign out_status = !(found_reg && (res_div_reg != '0));
    assign out_dbl    = out_status ? 1'b0 : dbl_reg;
    assign out_scale  = out_status ? '0 : SCALE_W'(trial_reg - SCALE_ZERO);
    assign out_div    = out_status ? '0 : res_div_reg;

    // Configuration register and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clk_hz_reg  <= CLK_HZ_RESET;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                clk_hz_reg <= cfg_wr_data;
            end
            if (cmd.publish)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Request and search registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            baud_reg  <= s_tdata[BAUD_W-1:0];
            dbl_reg   <= 1'b0;
            trial_reg <= '0;
            found_reg <= 1'b0;
        end
        if (cmd.cap_ratio)
        begin
            dbl_reg <= (quo <= DOUBLE_LIMIT);
        end
        if (cmd.check)
        begin
            if (sts.fit)
            begin
                found_reg   <= 1'b1;
                res_div_reg <= q_minus[DIVISOR_WIDTH-1:0];
            end
            else
            begin
                trial_reg <= trial_reg + TRIAL_W'(1);
            end
        end
        if (cmd.publish)
        begin
            m_data_reg <= OUT_W'({out_div, out_scale, out_dbl, out_status});
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

// ----- design/bds_ctrl.sv -----
// ----------------------------------------------------------------------------
// Baud divisor search controller
// Sequences the ratio division, the scale trials and the result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module bds_ctrl
    import bds_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    input  wire bds_sts_t sts,
    output bds_cmd_t      cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_RATIO  = 6'b000010,
        S_RWAIT  = 6'b000100,
        S_TRIAL  = 6'b001000,
        S_TWAIT  = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = sts.in_zero ? S_FINISH : S_RATIO;
                end
            end
            S_RATIO:
            begin
                cmd.start_div = 1'b1;
                cmd.sel_ratio = 1'b1;
                state_next    = S_RWAIT;
            end
            S_RWAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.cap_ratio = 1'b1;
                    state_next    = S_TRIAL;
                end
            end
            S_TRIAL:
            begin
                cmd.start_div = 1'b1;
                state_next    = S_TWAIT;
            end
            S_TWAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.check  = 1'b1;
                    state_next = (sts.fit || sts.last) ? S_FINISH : S_TRIAL;
                end
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire
